FILE: rtl/core/ffha_pkg.sv
// Shared constants and types for the first-fit heap allocator.
package ffha_pkg;

	localparam int POOL_WORDS_DEF = 1024;
	localparam int WORD_BYTES     = 8;
	localparam int WORD_SHIFT     = $clog2(WORD_BYTES);

	localparam int CFG_W  = 14;
	localparam int MODE_W = 2;
	localparam int REQ_W  = 14;
	localparam int OFF_W  = 13;
	localparam int STAT_W = 2;
	localparam int LF_W   = 14;
	localparam int NEED_W = 15;
	localparam int DATA_W = 32;

	localparam logic [CFG_W-1:0] POOL_BYTES_RST = 14'd8192;
	localparam logic [LF_W-1:0]  LF_MAX         = 14'h3FFF;

	localparam int RAM_WIDTH_DEF = $clog2(POOL_WORDS_DEF * WORD_BYTES) + 1;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC  = 2'd0,
		MODE_FREE   = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_FORMAT = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_SPACE = 2'd1,
		STAT_BAD_REQ  = 2'd2
	} stat_t;

endpackage

FILE: rtl/core/ffha_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
module ffha_ram #(
	parameter int WIDTH = ffha_pkg::RAM_WIDTH_DEF,
	parameter int DEPTH = ffha_pkg::POOL_WORDS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first on a same-address collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: request sequencer around the header RAM.
//
// Requests enter on the s_ group, one transaction per request; each request
// gives exactly one result transaction on the m_ group. s_tuser selects the
// request: allocate, free, largest-free query or format. The user is to write
// the pool size on the cfg_ channel only while no request is in flight; the
// block itself does not enforce this. The block works on one request at a
// time; s_tready is high only when idle. Format writes the first block header
// and then the end marker; free reads the block header and writes it back
// marked free; an ignored free or a request answered at once goes straight
// to the result. Allocate and query walk the block headers held in the RAM,
// merging neighbouring free blocks on the way, and an allocation then splits
// off any remainder of the block it takes and marks it used. The header RAM
// has one read and one write port with registered read data.
// The result sits in an output register; a stalled receiver holds it there,
// and the next request may be accepted meanwhile but cannot finish until the
// register is free. Reset clears the formatted flag and sets the pool size
// to 8192 bytes; the header RAM is not cleared and needs a format first.
module first_fit_heap_allocator_unit #(
	parameter int POOL_WORDS = ffha_pkg::POOL_WORDS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// [13:0] request_bytes, [26:14] free_offset, [31:27] zero
	input  logic [ffha_pkg::DATA_W-1:0] s_tdata,
	// [1:0] mode
	input  logic [ffha_pkg::MODE_W-1:0] s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [12:0] alloc_offset, [26:13] largest_free, [31:27] zero
	output logic [ffha_pkg::DATA_W-1:0] m_tdata,
	// [1:0] status
	output logic [ffha_pkg::STAT_W-1:0] m_tuser,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	// [13:0] pool_bytes
	input  logic [ffha_pkg::CFG_W-1:0]  cfg_data
);

	localparam int AW      = $clog2(POOL_WORDS);
	localparam int HDR_W   = $clog2(POOL_WORDS * ffha_pkg::WORD_BYTES) + 1;
	localparam int IW      = (AW + 2 > 12) ? AW + 2 : 12;
	localparam int NEED_W  = ffha_pkg::NEED_W;
	localparam int SZ_W    = (HDR_W > NEED_W) ? HDR_W : NEED_W;
	localparam int STEP_W  = HDR_W - ffha_pkg::WORD_SHIFT;
	localparam int SH      = ffha_pkg::WORD_SHIFT;
	localparam int WB      = ffha_pkg::WORD_BYTES;
	localparam int REQ_W   = ffha_pkg::REQ_W;
	localparam int OFF_W   = ffha_pkg::OFF_W;
	localparam int LF_W    = ffha_pkg::LF_W;
	localparam int OUT_PAD = ffha_pkg::DATA_W - OFF_W - LF_W;

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b00000000001,
		ST_FMT     = 11'b00000000010,
		ST_FMT_END = 11'b00000000100,
		ST_FREE_WR = 11'b00000001000,
		ST_LOAD    = 11'b00000010000,
		ST_CHECK   = 11'b00000100000,
		ST_MERGE   = 11'b00001000000,
		ST_SPLIT   = 11'b00010000000,
		ST_TAKE    = 11'b00100000000,
		ST_EMIT    = 11'b01000000000,
		ST_SPARE   = 11'b10000000000
	} state_t;

	// control state
	state_t                         state_q, state_d;
	logic                           fmt_q, fmt_d;
	logic [IW-1:0]                  active_q, active_d;
	logic [ffha_pkg::CFG_W-1:0]     pool_bytes_q;
	logic                           m_tvalid_q, m_valid_d;

	// payload
	ffha_pkg::mode_t                mode_q, mode_d;
	logic [NEED_W-1:0]              need_q, need_d;
	logic [AW-1:0]                  walk_q, walk_d;
	logic [HDR_W-1:0]               hb_q, hb_d;
	logic [HDR_W-1:0]               best_q, best_d;
	logic [AW-1:0]                  free_addr_q, free_addr_d;
	ffha_pkg::stat_t                res_status_q, res_status_d;
	logic [OFF_W-1:0]               res_doff_q, res_doff_d;
	logic [LF_W-1:0]                res_lf_q, res_lf_d;
	logic [ffha_pkg::STAT_W-1:0]    m_tuser_q, m_user_d;
	logic [ffha_pkg::DATA_W-1:0]    m_tdata_q, m_data_d;

	// RAM port
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [HDR_W-1:0]               ram_wdata;
	logic [AW-1:0]                  ram_raddr;
	logic [HDR_W-1:0]               ram_rdata;

	// request decode
	logic [REQ_W-1:0]               in_req;
	logic [OFF_W-1:0]               in_off;
	logic [NEED_W-1:0]              in_rq;
	logic [NEED_W-1:0]              in_need;
	logic [IW-1:0]                  in_dw;
	logic                           in_free_ok;

	// format decode
	logic [IW-1:0]                  pbw;
	logic [IW-1:0]                  fmt_w;

	// walk datapath
	logic [HDR_W-1:0]               hb_sz;
	logic                           hb_free;
	logic [STEP_W-1:0]              step;
	logic [IW-1:0]                  nx;
	logic                           has_next;
	logic                           is_end;
	logic                           fits;
	logic [HDR_W-1:0]               rd_sz;
	logic                           rd_ok;
	logic [HDR_W-1:0]               merged;
	logic [HDR_W-1:0]               rem;
	logic [IW-1:0]                  split;

	function automatic logic [LF_W-1:0] lf_of(input logic [HDR_W-1:0] b);
		logic [HDR_W-1:0] v;
		v = (b < HDR_W'(WB)) ? '0 : b - HDR_W'(WB);
		if (SZ_W'(v) > SZ_W'(ffha_pkg::LF_MAX)) begin
			return ffha_pkg::LF_MAX;
		end
		return LF_W'(v);
	endfunction

	ffha_ram #(
		.WIDTH(HDR_W),
		.DEPTH(POOL_WORDS)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign in_req     = s_tdata[REQ_W-1:0];
	assign in_off     = s_tdata[REQ_W +: OFF_W];
	assign in_rq      = NEED_W'(in_req) + NEED_W'(WB - 1);
	assign in_need    = ((in_rq >> SH) << SH) + NEED_W'(WB);
	assign in_dw      = IW'(in_off >> SH);
	assign in_free_ok = fmt_q && (in_dw != '0) && ((in_dw - IW'(1)) < active_q);

	assign pbw   = IW'(pool_bytes_q >> SH);
	assign fmt_w = (pbw < IW'(2)) ? IW'(2) :
	               ((pbw > IW'(POOL_WORDS)) ? IW'(POOL_WORDS) : pbw);

	assign hb_sz    = {hb_q[HDR_W-1:1], 1'b0};
	assign hb_free  = !hb_q[0];
	assign step     = hb_sz[HDR_W-1:SH];
	assign nx       = IW'(walk_q) + IW'(step);
	assign has_next = (step != '0) && (nx < active_q);
	assign is_end   = (hb_q == HDR_W'(1));
	assign fits     = SZ_W'(hb_sz) >= SZ_W'(need_q);
	assign rd_sz    = {ram_rdata[HDR_W-1:1], 1'b0};
	assign rd_ok    = !ram_rdata[0] && (rd_sz != '0);
	assign merged   = hb_q + ram_rdata;
	assign rem      = hb_sz - HDR_W'(need_q);
	assign split    = IW'(walk_q) + IW'(need_q >> SH);

	always_comb begin
		state_d      = state_q;
		fmt_d        = fmt_q;
		active_d     = active_q;
		m_valid_d    = m_tvalid_q;
		mode_d       = mode_q;
		need_d       = need_q;
		walk_d       = walk_q;
		hb_d         = hb_q;
		best_d       = best_q;
		free_addr_d  = free_addr_q;
		res_status_d = res_status_q;
		res_doff_d   = res_doff_q;
		res_lf_d     = res_lf_q;
		m_user_d     = m_tuser_q;
		m_data_d     = m_tdata_q;
		ram_we       = 1'b0;
		ram_waddr    = walk_q;
		ram_wdata    = merged;
		ram_raddr    = AW'(nx);

		if (m_tready) begin
			m_valid_d = 1'b0;
		end

		case (state_q)
			ST_IDLE: begin
				ram_raddr = (s_tuser == ffha_pkg::MODE_FREE) ? AW'(in_dw - IW'(1)) : '0;
				if (s_tvalid) begin
					mode_d       = ffha_pkg::mode_t'(s_tuser);
					need_d       = in_need;
					walk_d       = '0;
					best_d       = '0;
					free_addr_d  = AW'(in_dw - IW'(1));
					res_status_d = ffha_pkg::STAT_OK;
					res_doff_d   = '0;
					res_lf_d     = '0;
					case (ffha_pkg::mode_t'(s_tuser))
						ffha_pkg::MODE_FORMAT: state_d = ST_FMT;
						ffha_pkg::MODE_FREE: state_d = in_free_ok ? ST_FREE_WR : ST_EMIT;
						ffha_pkg::MODE_ALLOC: begin
							if (in_req == '0) begin
								res_status_d = ffha_pkg::STAT_BAD_REQ;
								state_d      = ST_EMIT;
							end else if (!fmt_q) begin
								res_status_d = ffha_pkg::STAT_NO_SPACE;
								state_d      = ST_EMIT;
							end else begin
								state_d = ST_LOAD;
							end
						end
						ffha_pkg::MODE_QUERY: state_d = fmt_q ? ST_LOAD : ST_EMIT;
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_FMT: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = HDR_W'(fmt_w - IW'(1)) << SH;
				state_d   = ST_FMT_END;
			end
			ST_FMT_END: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(fmt_w - IW'(1));
				ram_wdata = HDR_W'(1);
				active_d  = fmt_w;
				fmt_d     = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_FREE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = free_addr_q;
				ram_wdata = {ram_rdata[HDR_W-1:1], 1'b0};
				state_d   = ST_EMIT;
			end
			ST_LOAD: begin
				hb_d    = ram_rdata;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (is_end) begin
					if (mode_q == ffha_pkg::MODE_ALLOC) begin
						res_status_d = ffha_pkg::STAT_NO_SPACE;
					end else begin
						res_lf_d = lf_of(best_q);
					end
					state_d = ST_EMIT;
				end else if (hb_free && (mode_q == ffha_pkg::MODE_ALLOC) && fits) begin
					state_d = ST_SPLIT;
				end else if (hb_free && has_next) begin
					// read the following header for a merge attempt
					state_d = ST_MERGE;
				end else begin
					if ((mode_q == ffha_pkg::MODE_QUERY) && hb_free && (hb_sz > best_q)) begin
						best_d = hb_sz;
					end
					if (has_next) begin
						walk_d  = AW'(nx);
						state_d = ST_LOAD;
					end else begin
						if (mode_q == ffha_pkg::MODE_ALLOC) begin
							res_status_d = ffha_pkg::STAT_NO_SPACE;
						end else begin
							res_lf_d = lf_of(best_d);
						end
						state_d = ST_EMIT;
					end
				end
			end
			ST_MERGE: begin
				if (rd_ok) begin
					ram_we    = 1'b1;
					ram_waddr = walk_q;
					ram_wdata = merged;
					hb_d      = merged;
				end else begin
					// merge blocked: this block is final, the header just read is the next one
					if ((mode_q == ffha_pkg::MODE_QUERY) && (hb_sz > best_q)) begin
						best_d = hb_sz;
					end
					walk_d = AW'(nx);
					hb_d   = ram_rdata;
				end
				state_d = ST_CHECK;
			end
			ST_SPLIT: begin
				if ((rem != '0) && (split < active_q)) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(split);
					ram_wdata = rem;
				end
				state_d = ST_TAKE;
			end
			ST_TAKE: begin
				ram_we     = 1'b1;
				ram_waddr  = walk_q;
				ram_wdata  = HDR_W'(need_q) | HDR_W'(1);
				res_doff_d = OFF_W'({IW'(walk_q) + IW'(1), {SH{1'b0}}});
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (!m_tvalid_q || m_tready) begin
					m_valid_d = 1'b1;
					m_user_d  = res_status_q;
					m_data_d  = {{OUT_PAD{1'b0}}, res_lf_q, res_doff_q};
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fmt_q        <= 1'b0;
			active_q     <= '0;
			pool_bytes_q <= ffha_pkg::POOL_BYTES_RST;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			fmt_q      <= fmt_d;
			active_q   <= active_d;
			m_tvalid_q <= m_valid_d;
			if (cfg_valid) begin
				pool_bytes_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_q       <= mode_d;
		need_q       <= need_d;
		walk_q       <= walk_d;
		hb_q         <= hb_d;
		best_q       <= best_d;
		free_addr_q  <= free_addr_d;
		res_status_q <= res_status_d;
		res_doff_q   <= res_doff_d;
		res_lf_q     <= res_lf_d;
		m_tuser_q    <= m_user_d;
		m_tdata_q    <= m_data_d;
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = m_tuser_q;
	assign m_tdata   = m_tdata_q;

endmodule

FILE: rtl/core/ffha_checker.sv
// Port-level assertions for the first-fit heap allocator, bound to the top level.
module ffha_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [ffha_pkg::DATA_W-1:0] m_tdata,
	input logic [ffha_pkg::STAT_W-1:0] m_tuser
);

	// one request in flight: an accepted transaction drops ready
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("s_tready stayed high after an accepted request");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ffha_pkg::STAT_OK || m_tuser == ffha_pkg::STAT_NO_SPACE ||
		              m_tuser == ffha_pkg::STAT_BAD_REQ))
		else $error("result carries an unknown status");

	// a failed request returns neither offset nor size
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ffha_pkg::STAT_OK) |-> (m_tdata == '0))
		else $error("failed request returned a non-zero payload");

	a_offset_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[ffha_pkg::WORD_SHIFT-1:0] == '0))
		else $error("data offset is not word aligned");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed or was dropped");

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (.*);
